### src/shallow_water_edge_flux_assert.svh
// Assertion macros for the edge flux block checker.
`ifndef SHALLOW_WATER_EDGE_FLUX_ASSERT_SVH
`define SHALLOW_WATER_EDGE_FLUX_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define SWEF_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Implication checked in the cycle after the condition.
`define SWEF_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### src/swef_pkg.sv
// Shared types and constants of the shallow water edge flux block.
package swef_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 20;
	localparam int ACC_W     = 48;
	localparam int Q_W       = DATA_W - 1;        // unsigned magnitudes
	localparam int DIFF_W    = DATA_W + 1;        // side differences
	localparam int LEN_W     = 31;
	localparam int NRM_W     = 22;
	localparam int RAD_W     = 2 * Q_W;           // gravity times height
	localparam int NUM_W     = ACC_W + FRAC_BITS + 1;

	localparam logic [Q_W-1:0] Q_MAX = '1;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

	localparam int S_TDATA_W = 272;
	localparam int M_TDATA_W = 192;
	localparam int CFG_IDX_W = 8;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_EPS   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_AREA   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_RADIUS = 8'd3;

	localparam logic [Q_W-1:0] GRAVITY_RST = 31'd10286531;
	localparam logic [Q_W-1:0] ONE_Q       = 31'd1048576;

	typedef struct packed {
		logic [Q_W-1:0] gravity;
		logic [Q_W-1:0] speed_epsilon;
		logic [Q_W-1:0] cell_area;
		logic [Q_W-1:0] cell_radius;
	} cfg_t;

	// Classified edge handed from the front to the back.
	typedef struct packed {
		logic [Q_W-1:0]           hl_pos;
		logic [Q_W-1:0]           hr_pos;
		logic signed [DIFF_W-1:0] dh;
		logic signed [DIFF_W-1:0] dxm;
		logic signed [DIFF_W-1:0] dym;
		logic [LEN_W-1:0]         len;
		logic signed [NRM_W-1:0]  nx;
		logic signed [NRM_W-1:0]  ny;
		logic                     last_edge;
		logic                     last_element;
	} edge_t;

endpackage

### src/swef_sqrt.sv
// Digit-serial integer square root, one result bit per cycle.
module swef_sqrt
	import swef_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RAD_W-1:0] radicand,
	output logic             done,
	output logic [Q_W-1:0]   root
);

	logic [RAD_W-1:0] x_q;
	logic [Q_W+1:0]   rem_q;
	logic [Q_W-1:0]   root_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [Q_W+3:0]   tmp;
	logic [Q_W+3:0]   trial;
	logic             take;

	// Form the trial subtraction for this digit
	always_comb begin
		tmp   = {rem_q, x_q[RAD_W-1:RAD_W-2]};
		trial = (Q_W+4)'({root_q, 2'b01});
		take  = tmp >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && cnt_q == 5'(Q_W - 1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(Q_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Advance the remainder and the root
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[RAD_W-3:0], 2'b00};
			rem_q  <= take ? (Q_W+2)'(tmp - trial) : tmp[Q_W+1:0];
			root_q <= {root_q[Q_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### src/swef_div.sv
// Restoring divider for Q quotients, saturating at the largest magnitude.
module swef_div
	import swef_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [Q_W-1:0]   den,
	output logic             done,
	output logic [Q_W-1:0]   quo
);

	logic [Q_W-1:0] r_q;
	logic [Q_W-1:0] lo_q;
	logic [Q_W-1:0] quo_q;
	logic [Q_W-1:0] den_q;
	logic [4:0]     cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [Q_W:0]   t;
	logic           take;
	logic           ovf;

	always_comb begin
		t    = {r_q, lo_q[Q_W-1]};
		take = t >= {1'b0, den_q};
		ovf  = num >= NUM_W'({den, {Q_W{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				done_q <= den == '0 || ovf;
			end else begin
				done_q <= busy_q && cnt_q == 5'(Q_W - 1);
			end
			if (start) begin
				cnt_q <= '0;
				if (!(den == '0 || ovf)) begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(Q_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Load the operands or shift one quotient bit in
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			r_q   <= num[2*Q_W-1:Q_W];
			lo_q  <= num[Q_W-1:0];
			if (den == '0) begin
				quo_q <= (num != '0) ? Q_MAX : '0;
			end else if (ovf) begin
				quo_q <= Q_MAX;
			end else begin
				quo_q <= '0;
			end
		end else if (busy_q) begin
			r_q   <= take ? Q_W'(t - {1'b0, den_q}) : t[Q_W-1:0];
			lo_q  <= {lo_q[Q_W-2:0], 1'b0};
			quo_q <= {quo_q[Q_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### src/swef_front.sv
// Input side: unpacks and classifies edges into a short queue.
module swef_front
	import swef_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,
	input  logic [1:0]           s_tuser,
	input  logic                 pop,
	output logic                 q_valid,
	output edge_t                q_data
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	edge_t                    mem_q [DEPTH];
	logic [PTR_W-1:0]         wr_q;
	logic [PTR_W-1:0]         rd_q;
	logic [PTR_W:0]           cnt_q;
	edge_t                    cls;
	logic signed [DATA_W-1:0] hl, hr, nh, nxm, nym, uhk, vhk;
	logic signed [DIFF_W-1:0] uhr, vhr;
	logic                     has_nb;
	logic                     push;

	// Pick the far side: neighbour values or the mirrored wall state
	always_comb begin
		hl     = $signed(s_tdata[31:0]);
		nh     = $signed(s_tdata[63:32]);
		nxm    = $signed(s_tdata[95:64]);
		nym    = $signed(s_tdata[127:96]);
		uhk    = $signed(s_tdata[159:128]);
		vhk    = $signed(s_tdata[191:160]);
		has_nb = s_tuser[0];
		hr     = has_nb ? nh : hl;
		uhr    = has_nb ? DIFF_W'(nxm) : -DIFF_W'(uhk);
		vhr    = has_nb ? DIFF_W'(nym) : -DIFF_W'(vhk);
		cls.hl_pos       = hl[DATA_W-1] ? '0 : hl[Q_W-1:0];
		cls.hr_pos       = hr[DATA_W-1] ? '0 : hr[Q_W-1:0];
		cls.dh           = DIFF_W'(hl) - DIFF_W'(hr);
		cls.dxm          = DIFF_W'(uhk) - uhr;
		cls.dym          = DIFF_W'(vhk) - vhr;
		cls.len          = s_tdata[222:192];
		cls.nx           = $signed(s_tdata[244:223]);
		cls.ny           = $signed(s_tdata[266:245]);
		cls.last_edge    = s_tlast;
		cls.last_element = s_tuser[1];
	end

	assign s_tready = cnt_q != (PTR_W+1)'(DEPTH);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = cnt_q != '0;
	assign q_data   = mem_q[rd_q];

	// Advance the queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cls;
	end

endmodule

### src/swef_back.sv
// Flux engine: wave speeds, flux products, sums and element results.
module swef_back
	import swef_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 q_valid,
	input  edge_t                q_data,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_GRAV = 7'b0000010,
		ST_SQRT = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_ACC  = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t                   state_q;
	edge_t                    ent_q;
	logic [RAD_W-1:0]         gl_q, gr_q;
	logic                     sq_go_q, div_go_q;
	logic                     sq_done_l, sq_done_r;
	logic [Q_W-1:0]           root_l, root_r;
	logic [Q_W-1:0]           cm_q;
	logic [2:0]               step_q;
	logic signed [DATA_W-1:0] mul_q, st_q, xt_q, yt_q;
	logic signed [ACC_W-1:0]  sacc_q, xacc_q, yacc_q;
	logic [Q_W-1:0]           peak_q, min_q, ts_q;
	logic                     valid_q;
	logic [1:0]               dsel_q;
	logic signed [DATA_W-1:0] sr_q, xr_q, yr_q;
	logic                     mv_q;
	logic [M_TDATA_W-1:0]     md_q;
	logic                     ml_q, mu_q;

	logic signed [DIFF_W:0]   ma, mb;
	logic [DIFF_W-1:0]        am, bm;
	logic [2*DIFF_W-1:0]      pm;
	logic [2*DIFF_W-1-FRAC_BITS:0] ps;
	logic [Q_W-1:0]           pmag;
	logic signed [DATA_W-1:0] mres;
	logic signed [ACC_W-1:0]  sacc_n, xacc_n, yacc_n;
	logic [Q_W-1:0]           peak_n;
	logic signed [ACC_W-1:0]  dacc;
	logic [ACC_W-2:0]         dmag;
	logic [NUM_W-1:0]         dnum;
	logic [Q_W-1:0]           dden;
	logic                     d_done;
	logic [Q_W-1:0]           d_quo;
	logic signed [DATA_W-1:0] d_rate;
	logic [Q_W-1:0]           min_n;
	logic                     out_free;

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0]  acc,
		input logic signed [DATA_W-1:0] term
	);
		logic signed [ACC_W:0] s;
		s = (ACC_W+1)'(acc) + (ACC_W+1)'(term);
		if (s > (ACC_W+1)'(ACC_MAX)) return ACC_MAX;
		if (s < -(ACC_W+1)'(ACC_MAX)) return -ACC_MAX;
		return s[ACC_W-1:0];
	endfunction

	swef_sqrt u_sqrt_l (
		.clk(clk), .arst_n(arst_n), .start(sq_go_q), .radicand(gl_q),
		.done(sq_done_l), .root(root_l)
	);

	swef_sqrt u_sqrt_r (
		.clk(clk), .arst_n(arst_n), .start(sq_go_q), .radicand(gr_q),
		.done(sq_done_r), .root(root_r)
	);

	// Select operands of the shared flux multiplier
	always_comb begin
		unique case (step_q)
			3'd0: begin
				ma = (DIFF_W+1)'(cm_q);
				mb = (DIFF_W+1)'(ent_q.dh);
			end
			3'd2: begin
				ma = (DIFF_W+1)'(cm_q);
				mb = (DIFF_W+1)'(ent_q.dxm);
			end
			3'd5: begin
				ma = (DIFF_W+1)'(cm_q);
				mb = (DIFF_W+1)'(ent_q.dym);
			end
			3'd4: begin
				ma = (DIFF_W+1)'(mul_q);
				mb = (DIFF_W+1)'(ent_q.nx);
			end
			3'd7: begin
				ma = (DIFF_W+1)'(mul_q);
				mb = (DIFF_W+1)'(ent_q.ny);
			end
			default: begin
				ma = (DIFF_W+1)'(mul_q);
				mb = (DIFF_W+1)'(ent_q.len);
			end
		endcase
		am   = ma[DIFF_W] ? DIFF_W'(-ma) : ma[DIFF_W-1:0];
		bm   = mb[DIFF_W] ? DIFF_W'(-mb) : mb[DIFF_W-1:0];
		pm   = am * bm;
		ps   = pm[2*DIFF_W-1:FRAC_BITS];
		pmag = (ps > $bits(ps)'(Q_MAX)) ? Q_MAX : ps[Q_W-1:0];
		mres = (ma[DIFF_W] ^ mb[DIFF_W]) ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
	end

	// Next sums and peak speed for this edge
	always_comb begin
		sacc_n = sat_add(sacc_q, st_q);
		xacc_n = sat_add(xacc_q, xt_q);
		yacc_n = sat_add(yacc_q, yt_q);
		peak_n = (cm_q > cfg.speed_epsilon && cm_q > peak_q) ? cm_q : peak_q;
	end

	// Divider operands: timestep first, then the three rates
	always_comb begin
		unique case (dsel_q)
			2'd1:    dacc = sacc_q;
			2'd2:    dacc = xacc_q;
			default: dacc = yacc_q;
		endcase
		dmag = dacc[ACC_W-1] ? (ACC_W-1)'(-dacc) : dacc[ACC_W-2:0];
		if (dsel_q == 2'd0) begin
			dnum = NUM_W'({cfg.cell_radius, {FRAC_BITS{1'b0}}});
			dden = peak_q;
		end else begin
			dnum = NUM_W'({dmag, {FRAC_BITS{1'b0}}});
			dden = cfg.cell_area;
		end
		d_rate = dacc[ACC_W-1] ? -$signed({1'b0, d_quo}) : $signed({1'b0, d_quo});
	end

	swef_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .num(dnum), .den(dden),
		.done(d_done), .quo(d_quo)
	);

	assign min_n    = (valid_q && ts_q < min_q) ? ts_q : min_q;
	assign out_free = !mv_q || m_tready;
	assign pop      = (state_q == ST_IDLE) && q_valid;

	// Sequence one edge through the engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sq_go_q  <= 1'b0;
			div_go_q <= 1'b0;
			step_q   <= '0;
			dsel_q   <= '0;
			sacc_q   <= '0;
			xacc_q   <= '0;
			yacc_q   <= '0;
			peak_q   <= '0;
			min_q    <= Q_MAX;
			mv_q     <= 1'b0;
		end else begin
			sq_go_q  <= state_q == ST_GRAV;
			div_go_q <= (state_q == ST_ACC && ent_q.last_edge) ||
				(state_q == ST_DIV && d_done && dsel_q != 2'd3);
			if (state_q == ST_OUT && out_free) mv_q <= 1'b1;
			else if (m_tready) mv_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) state_q <= ST_GRAV;
				end
				ST_GRAV: begin
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_done_l && sq_done_r) begin
						step_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) state_q <= ST_ACC;
				end
				ST_ACC: begin
					sacc_q <= sacc_n;
					xacc_q <= xacc_n;
					yacc_q <= yacc_n;
					peak_q <= peak_n;
					if (ent_q.last_edge) begin
						dsel_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (d_done) begin
						if (dsel_q == 2'd3) begin
							state_q <= ST_OUT;
						end else begin
							dsel_q <= dsel_q + 2'd1;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						sacc_q  <= '0;
						xacc_q  <= '0;
						yacc_q  <= '0;
						peak_q  <= '0;
						min_q   <= ent_q.last_element ? Q_MAX : min_n;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold operands and partial results
	always_ff @(posedge clk) begin
		if (pop) ent_q <= q_data;
		if (state_q == ST_GRAV) begin
			gl_q <= cfg.gravity * ent_q.hl_pos;
			gr_q <= cfg.gravity * ent_q.hr_pos;
		end
		if (state_q == ST_SQRT && sq_done_l && sq_done_r) begin
			cm_q <= (root_l > root_r) ? root_l : root_r;
		end
		if (state_q == ST_MUL) begin
			mul_q <= mres;
			if (step_q == 3'd1) st_q <= mres;
			if (step_q == 3'd4) xt_q <= mres;
			if (step_q == 3'd7) yt_q <= mres;
		end
		if (state_q == ST_ACC) valid_q <= peak_n > cfg.speed_epsilon;
		if (state_q == ST_DIV && d_done) begin
			unique case (dsel_q)
				2'd0:    ts_q <= valid_q ? d_quo : '0;
				2'd1:    sr_q <= d_rate;
				2'd2:    xr_q <= d_rate;
				default: yr_q <= d_rate;
			endcase
		end
		if (state_q == ST_OUT && out_free) begin
			md_q <= {3'b000, min_n, ts_q, valid_q ? peak_q : {Q_W{1'b0}},
				yr_q, xr_q, sr_q};
			ml_q <= ent_q.last_element;
			mu_q <= valid_q;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = md_q;
	assign m_tlast  = ml_q;
	assign m_tuser  = mu_q;

endmodule

### src/shallow_water_edge_flux.sv
// Top level of the shallow water edge flux block.
// Usage:
//   Edges enter on the s_ stream, one request per triangle edge; tlast
//   closes the element and tuser[1] marks the sweep's last element.
//   A four-entry queue takes edges while the flux engine works on an
//   earlier one, so the sender stalls only when the queue is full.
//   Each edge goes through the engine in order: it is taken from the
//   queue, gravity times height is formed, the two 31-step square root
//   units run side by side, eight flux products run on one shared
//   multiplier, then the sums are accumulated.
//   An element's last edge adds four 31-step divisions on one shared
//   divider (timestep and three rates) before the result request appears
//   on the m_ stream. The result sits in an output register; the engine
//   keeps taking edges until it needs that register again while m_tready
//   is low. Registers are to be written through cfg_ while no edge is
//   in flight; the block itself does not enforce this. Reset restores
//   the register defaults, clears the sums and peak speed and sets the
//   sweep minimum to its largest value.
module shallow_water_edge_flux
	import swef_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// edge_height, neighbour_height, neighbour_xmom, neighbour_ymom,
	// own_xmom, own_ymom, edge_length, normal_x, normal_y, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,         // last_edge
	input  logic [1:0]           s_tuser,         // has_neighbour, last_element
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// stage_rate, xmom_rate, ymom_rate, elem_max_speed, elem_timestep,
	// sweep_min_timestep, zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast,         // sweep_done
	output logic                 m_tuser,         // timestep_valid
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	cfg_t  cfg_q;
	logic  q_valid;
	edge_t q_data;
	logic  pop;

	assign cfg_ready = 1'b1;

	// Write configuration registers, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity       <= GRAVITY_RST;
			cfg_q.speed_epsilon <= '0;
			cfg_q.cell_area     <= ONE_Q;
			cfg_q.cell_radius   <= ONE_Q;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GRAVITY:     cfg_q.gravity       <= cfg_data[Q_W-1:0];
				CFG_SPEED_EPS:   cfg_q.speed_epsilon <= cfg_data[Q_W-1:0];
				CFG_CELL_AREA:   cfg_q.cell_area     <= cfg_data[Q_W-1:0];
				CFG_CELL_RADIUS: cfg_q.cell_radius   <= cfg_data[Q_W-1:0];
				default: ;
			endcase
		end
	end

	swef_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.pop(pop), .q_valid(q_valid), .q_data(q_data)
	);

	swef_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_data(q_data), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

endmodule

### src/swef_checker.sv
// Port-level checker for the edge flux block, bound to the top level.
`include "shallow_water_edge_flux_assert.svh"

module swef_checker
	import swef_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser
);

	// Stalled result stays offered and unchanged
	`SWEF_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped")
	`SWEF_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "result changed")

	// No valid speed means no speed and no timestep
	`SWEF_ASSERT_IMP(a_no_speed, m_tvalid && !m_tuser,
		m_tdata[157:127] == '0 && m_tdata[126:96] == '0, "speed without valid")

	// Sweep minimum already includes this element's timestep
	`SWEF_ASSERT_IMP(a_min, m_tvalid && m_tuser,
		m_tdata[188:158] <= m_tdata[157:127], "sweep minimum above timestep")

endmodule

bind shallow_water_edge_flux swef_checker u_swef_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);

### bench/tb.sv
// Self-checking bench for the shallow water edge flux block.
module tb;
	import swef_pkg::*;

	typedef struct {
		logic signed [31:0] h;
		logic               nb;
		logic signed [31:0] nh;
		logic signed [31:0] nxm;
		logic signed [31:0] nym;
		logic signed [31:0] oxm;
		logic signed [31:0] oym;
		logic [30:0]        len;
		logic signed [21:0] nx;
		logic signed [21:0] ny;
		logic               last_edge;
		logic               last_elem;
	} edge_req_t;

	typedef struct {
		logic signed [31:0] stage;
		logic signed [31:0] xmom;
		logic signed [31:0] ymom;
		logic [30:0]        speed;
		logic [30:0]        tstep;
		logic               tvalid;
		logic [30:0]        smin;
		logic               done;
	} flux_res_t;

	typedef struct {
		edge_req_t e;
		logic      typed;
		flux_res_t r;
	} row_t;

	localparam longint DMAX = 64'h7FFF_FFFF;
	localparam longint AMAX = (64'sd1 <<< 47) - 1;
	localparam longint LIMIT_CYCLES = 3000000;
	localparam logic [CFG_IDX_W-1:0] CFG_BAD_A = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BAD_B = 8'd255;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;

	// predictor state and configuration
	longint    gravity, speed_eps, cell_area, cell_radius;
	longint    stage_sum, xmom_sum, ymom_sum, peak_speed, sweep_min;
	flux_res_t flux_q[$];

	edge_req_t cur_edge;
	logic      s_fire = 1'b0;
	logic      cfg_fire = 1'b0;
	logic      typed_pending = 1'b0;
	flux_res_t typed_res;
	logic      hold_req = 1'b0;
	int        errors = 0;
	int        n_edges = 0;
	int        n_results = 0;
	longint    cycles = 0;
	row_t      rows[$];

	shallow_water_edge_flux u_top (.*);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_results);
	endtask

	function automatic longint qmul(longint a, longint b);
		logic [127:0] p;
		logic [63:0]  ma, mb;
		longint       r;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = {64'd0, ma} * {64'd0, mb};
		p = p >> FRAC_BITS;
		r = (p > DMAX) ? DMAX : longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint qdiv(longint num, longint den, longint lim);
		logic [127:0] q;
		if (den == 0)
			return num != 0 ? lim : 0;
		q = ({64'd0, num} << FRAC_BITS) / den;
		return (q > lim) ? lim : longint'(q[63:0]);
	endfunction

	function automatic longint isqrt(logic [63:0] x);
		logic [63:0] res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (x >= res + bit_v) begin
				x -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else
				res >>= 1;
			bit_v >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint acc_add(longint acc, longint t);
		if (t > 0 && acc > AMAX - t)
			return AMAX;
		if (t < 0 && acc < -AMAX - t)
			return -AMAX;
		return acc + t;
	endfunction

	function automatic longint area_rate(longint sum);
		longint m;
		m = qdiv(sum < 0 ? -sum : sum, cell_area, DMAX);
		return sum < 0 ? -m : m;
	endfunction

	function automatic longint wave_speed(longint h);
		return isqrt(gravity * (h > 0 ? h : 0));
	endfunction

	// Advance the flux sums by one edge; return 1 when a result is due.
	function automatic bit flux_step(edge_req_t e, output flux_res_t r);
		longint hl, hr, uhr, vhr, uhk, vhk, cm, cr, ts;
		bit     ok;
		hl = e.h;
		uhk = e.oxm;
		vhk = e.oym;
		if (e.nb) begin
			hr = e.nh;
			uhr = e.nxm;
			vhr = e.nym;
		end else begin
			hr = hl;
			uhr = -uhk;
			vhr = -vhk;
		end
		cm = wave_speed(hl);
		cr = wave_speed(hr);
		if (cr > cm)
			cm = cr;
		stage_sum = acc_add(stage_sum, qmul(qmul(cm, hl - hr), e.len));
		xmom_sum = acc_add(xmom_sum, qmul(qmul(qmul(cm, uhk - uhr), e.len), e.nx));
		ymom_sum = acc_add(ymom_sum, qmul(qmul(qmul(cm, vhk - vhr), e.len), e.ny));
		if (cm > speed_eps && cm > peak_speed)
			peak_speed = cm;
		r = '{default: '0};
		if (!e.last_edge)
			return 0;
		ok = peak_speed > speed_eps;
		ts = 0;
		if (ok) begin
			ts = qdiv(cell_radius, peak_speed, DMAX);
			if (ts < sweep_min)
				sweep_min = ts;
		end
		r.stage = area_rate(stage_sum);
		r.xmom = area_rate(xmom_sum);
		r.ymom = area_rate(ymom_sum);
		r.speed = ok ? peak_speed : 0;
		r.tstep = ts;
		r.tvalid = ok;
		r.smin = sweep_min;
		r.done = e.last_elem;
		stage_sum = 0;
		xmom_sum = 0;
		ymom_sum = 0;
		peak_speed = 0;
		if (e.last_elem)
			sweep_min = DMAX;
		return 1;
	endfunction

	// Sample requests on both input channels and predict results.
	always @(posedge clk) begin
		flux_res_t r;
		cycles++;
		s_fire = s_tvalid && s_tready;
		cfg_fire = cfg_valid && cfg_ready;
		if (cfg_fire) begin
			case (cfg_index)
				CFG_GRAVITY:     gravity = cfg_data[30:0];
				CFG_SPEED_EPS:   speed_eps = cfg_data[30:0];
				CFG_CELL_AREA:   cell_area = cfg_data[30:0];
				CFG_CELL_RADIUS: cell_radius = cfg_data[30:0];
				default: ;
			endcase
		end
		if (s_fire) begin
			n_edges++;
			if (flux_step(cur_edge, r))
				flux_q.push_back(typed_pending ? typed_res : r);
			typed_pending = 1'b0;
		end
	end

	// Check each result request against the oldest expectation.
	always @(posedge clk) begin
		flux_res_t w;
		if (m_tvalid && m_tready) begin
			n_results++;
			if (flux_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				w = flux_q.pop_front();
				if (m_tdata[31:0] !== w.stage)
					report_mismatch("stage_rate", m_tdata[31:0], w.stage);
				if (m_tdata[63:32] !== w.xmom)
					report_mismatch("xmom_rate", m_tdata[63:32], w.xmom);
				if (m_tdata[95:64] !== w.ymom)
					report_mismatch("ymom_rate", m_tdata[95:64], w.ymom);
				if (m_tdata[126:96] !== w.speed)
					report_mismatch("elem_max_speed", m_tdata[126:96], w.speed);
				if (m_tdata[157:127] !== w.tstep)
					report_mismatch("elem_timestep", m_tdata[157:127], w.tstep);
				if (m_tdata[188:158] !== w.smin)
					report_mismatch("sweep_min_timestep", m_tdata[188:158], w.smin);
				if (m_tuser !== w.tvalid)
					report_mismatch("timestep_valid", m_tuser, w.tvalid);
				if (m_tlast !== w.done)
					report_mismatch("sweep_done", m_tlast, w.done);
			end
		end
	end

	// Abort a hung run.
	always @(posedge clk) begin
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("[shallow_water_edge_flux] ERROR");
			$finish;
		end
	end

	// Stall the result side: short gaps, rare long ones, quiet stretches, one long hold.
	initial begin
		int gap;
		bit quiet;
		gap = 0;
		quiet = 0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 299) == 0)
				quiet = ~quiet;
			if (hold_req) begin
				hold_req = 1'b0;
				gap = 3000;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				gap--;
			end else begin
				m_tready <= 1'b1;
				if (!quiet) begin
					gap = $urandom_range(0, 99);
					if (gap < 15)
						gap = $urandom_range(1, 3);
					else if (gap < 17)
						gap = $urandom_range(20, 200);
					else
						gap = 0;
				end
			end
		end
	end

	function automatic edge_req_t mk(logic signed [31:0] h, logic nb, logic signed [31:0] nh,
			logic signed [31:0] nxm, logic signed [31:0] nym, logic signed [31:0] oxm,
			logic signed [31:0] oym, logic [30:0] len, logic signed [21:0] nx,
			logic signed [21:0] ny, logic le, logic lm);
		edge_req_t e;
		e = '{h, nb, nh, nxm, nym, oxm, oym, len, nx, ny, le, lm};
		return e;
	endfunction

	function automatic logic signed [31:0] rnd_height();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return $urandom;
		if (k == 1)
			return 32'h7FFF_FFFF;
		if (k == 2)
			return -$signed({1'b0, 31'($urandom_range(0, 1 << 22))});
		return $urandom_range(0, 100 << FRAC_BITS);
	endfunction

	function automatic logic signed [31:0] rnd_mom();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $signed(32'($urandom_range(0, 40 << FRAC_BITS))) - (20 << FRAC_BITS);
	endfunction

	function automatic edge_req_t rnd_edge(logic le, logic lm);
		edge_req_t e;
		e.h = rnd_height();
		e.nb = $urandom_range(0, 3) != 0;
		e.nh = rnd_height();
		e.nxm = rnd_mom();
		e.nym = rnd_mom();
		e.oxm = rnd_mom();
		e.oym = rnd_mom();
		e.len = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4 << 20));
		e.nx = $signed(22'($urandom_range(0, 2097152))) - 22'sd1048576;
		e.ny = $signed(22'($urandom_range(0, 2097152))) - 22'sd1048576;
		e.last_edge = le;
		e.last_elem = lm;
		return e;
	endfunction

	// Offer one edge request; called at a falling edge, returns at one.
	task automatic send_edge(edge_req_t e);
		int gap;
		cur_edge = e;
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, e.ny, e.nx, e.len, e.oym, e.oxm, e.nym, e.nxm, e.nh, e.h};
		s_tlast <= e.last_edge;
		s_tuser <= {e.last_elem, e.nb};
		do @(negedge clk); while (!s_fire);
		gap = $urandom_range(0, 99);
		gap = gap < 70 ? 0 : gap < 97 ? $urandom_range(1, 4) : $urandom_range(20, 150);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Hold the sender until every result is back and the engine has settled.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (flux_q.size() != 0)
			@(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic rnd_elements(int n_items);
		int k, ne;
		k = 0;
		while (k < n_items) begin
			ne = $urandom_range(0, 7) == 0 ? $urandom_range(1, 5) : 3;
			for (int i = 0; i < ne; i++)
				send_edge(rnd_edge(i == ne - 1, $urandom_range(0, 5) == 0));
			k += ne;
		end
	endtask

	initial begin
		logic [31:0] settings[8][4];
		flux_res_t   zero_res;
		flux_res_t   zero_done;
		zero_res = '{default: '0};
		zero_res.smin = DMAX;
		zero_done = zero_res;
		zero_done.done = 1'b1;
		gravity = GRAVITY_RST;
		speed_eps = 0;
		cell_area = ONE_Q;
		cell_radius = ONE_Q;
		stage_sum = 0;
		xmom_sum = 0;
		ymom_sum = 0;
		peak_speed = 0;
		sweep_min = DMAX;

		// directed edges: dry wall, extremes, wall reflection, sweep closing
		rows.push_back('{mk(0, 0, 32'h7FFF_FFFF, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF,
			31'h7FFF_FFFF, 22'sd1048576, -22'sd1048576, 1, 0), 1, zero_res});
		rows.push_back('{mk(-1, 0, 5, 5, 5, 5, 5, 31'd0, -22'sd1, -22'sd1, 1, 1), 1, zero_done});
		rows.push_back('{mk(32'h7FFF_FFFF, 1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 22'sd1048576, -22'sd1048576, 0, 0),
			0, zero_res});
		rows.push_back('{mk(32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, -22'sd1048576, 22'sd1048576, 1, 0),
			0, zero_res});
		for (int i = 0; i < 3; i++)
			rows.push_back('{mk(ONE_Q, 0, 0, 0, 0, 3 << 20, -(2 << 20), ONE_Q,
				22'sd741455, -22'sd741455, i == 2, 0), 0, zero_res});
		rows.push_back('{mk(2 << 20, 1, ONE_Q, 1 << 19, 0, 0, 1 << 18, ONE_Q,
			22'sd1048576, 0, 0, 1), 0, zero_res});
		rows.push_back('{mk(4 << 20, 1, 8 << 20, 0, 1 << 20, 1 << 20, 0, 2 << 20,
			0, 22'sd1048576, 1, 1), 0, zero_res});
		rows.push_back('{mk(-5, 1, -7, 3, 3, 3, 3, ONE_Q, 22'sd5, 22'sd5, 1, 0), 1, zero_res});

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (rows[i]) begin
			typed_pending = rows[i].typed;
			typed_res = rows[i].r;
			send_edge(rows[i].e);
		end
		rnd_elements(40);
		drain();

		// gravity, epsilon, area, radius per phase, extremes among them
		settings[0] = '{32'd1, 32'd0, 32'd1, 32'h7FFF_FFFF};
		settings[1] = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0};
		settings[2] = '{GRAVITY_RST, 32'd1 << 22, 32'd0, ONE_Q};
		settings[3] = '{GRAVITY_RST, 32'd0, 32'd433, 32'd300000};
		settings[4] = '{32'h7FFF_FFFF, 32'd1 << 26, ONE_Q >> 1, 32'hFFFF_FFFF};
		settings[5] = '{32'd1 << 20, 32'd0, 32'h7FFF_FFFF, ONE_Q};
		settings[6] = '{32'd2 << 20, 32'd1 << 18, 32'd3 << 20, 32'd1 << 19};
		settings[7] = '{GRAVITY_RST, 32'd0, ONE_Q, ONE_Q};
		for (int p = 0; p < 8; p++) begin
			write_reg(CFG_GRAVITY, settings[p][0]);
			write_reg(CFG_SPEED_EPS, settings[p][1]);
			write_reg(CFG_CELL_AREA, settings[p][2]);
			write_reg(CFG_CELL_RADIUS, settings[p][3]);
			write_reg(p[0] ? CFG_BAD_A : CFG_BAD_B, $urandom);
			if (p == 3)
				hold_req = 1'b1;
			rnd_elements(p == 3 ? 80 : 50);
			drain();
		end

		s_tvalid <= 1'b0;
		$display("edges sent %0d, results checked %0d, 9 register settings incl. extremes",
			n_edges, n_results);
		$display("covered walls, dry and negative heights, saturation, zero area, sweep ends");
		if (errors == 0 && flux_q.size() == 0)
			$display("[shallow_water_edge_flux] OK");
		else begin
			$display("%0d mismatches, %0d results missing", errors, flux_q.size());
			$display("[shallow_water_edge_flux] ERROR");
		end
		$finish;
	end

endmodule
